>>> hdl/multi_stream_xorshift_prng_core_defines.svh
// Assertion macros for the RTL core of the xorshift generator bank.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef MULTI_STREAM_XORSHIFT_PRNG_CORE_DEFINES_SVH
`define MULTI_STREAM_XORSHIFT_PRNG_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MSXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define MSXP_NEVER(lbl, expr, msg) \
  `MSXP_ASSERT(lbl, !(expr), msg)

`endif

>>> hdl/msxp_pkg.sv
// Types, constants and seed functions of the xorshift generator bank.
// Used by msxp_draw and the core; depends on nothing.
`default_nettype none

package msxp_pkg;

  localparam int NUM_CLASSES = 16;
  localparam int CLS_AW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam int SEED_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int FRAC_SHIFT = 4;
  localparam int BYTE_SHIFT = 8;

  localparam logic [31:0] SEED_DEFAULT = 32'hBADE4404;
  localparam logic [31:0] MIX_MULT     = 32'd36548569;

  typedef enum logic [3:0] {
    MODE_FRAC   = 4'd0,
    MODE_BYTE   = 4'd1,
    MODE_KEY    = 4'd2,
    MODE_RANGE  = 4'd3,
    MODE_PEEK   = 4'd4,
    MODE_QUERY  = 4'd5,
    MODE_SET    = 4'd6,
    MODE_SETALL = 4'd7,
    MODE_RESEED = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_FIN,
    S_SWEEP
  } state_e;

  // One xorshift generator step.
  function automatic logic [31:0] xs_advance(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s >> 13);
    t = t ^ (t >> 11);
    t = t ^ (t << 21);
    return t;
  endfunction

  // Chain step used when reseeding every class.
  function automatic logic [31:0] xs_scramble(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s >> 13);
    t = t ^ (t << 25);
    t = t ^ (t >> 11);
    return t;
  endfunction

  // Replace a zero seed by the default.
  function automatic logic [31:0] seed_nz(input logic [31:0] s);
    return (s == '0) ? SEED_DEFAULT : s;
  endfunction

endpackage

`default_nettype wire

>>> hdl/msxp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module msxp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/msxp_draw.sv
// Two-stage draw pipeline: seed mixing multiply, then fraction scaling.
// Depends on msxp_pkg for the mixing constant and widths.
`default_nettype none

module msxp_draw (
  input  wire logic                        clk_i,
  input  wire logic [msxp_pkg::SEED_W-1:0] seed_i,
  input  wire logic signed [31:0]          scale_i,
  output logic      [msxp_pkg::FRAC_W-1:0] frac_o,
  output logic      [31:0]                 scaled_o
);
  import msxp_pkg::*;

  logic [31:0]        mix_q;
  logic signed [48:0] prod_q;

  assign frac_o = mix_q[FRAC_SHIFT +: FRAC_W];

  always_ff @(posedge clk_i) begin
    mix_q  <= 32'(seed_i * MIX_MULT);
    prod_q <= $signed({1'b0, frac_o}) * scale_i;
  end

  // Floor division by 65536 of the signed product.
  assign scaled_o = prod_q[47:16];

endmodule

`default_nettype wire

>>> hdl/multi_stream_xorshift_prng_core.sv
// A per-class request passes through seed read and advance, mixing multiply, scaling multiply
// and write-back with result load, in that order, before its result beat.
// A new request is accepted only in the idle state, once the last one is done; reseed-all sweeps
// all NUM_CLASSES entries of the seed memories, one class per cycle as set by the single write
// port, then finishes and gives its result beat. A full output stalls.
// Reset: asynchronous, active low; all seed entries read as zero after reset
// through per-entry valid bits, no clearing pass is needed.
`default_nettype none

module multi_stream_xorshift_prng_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: class_index[3:0], first_bound[35:4], second_bound[67:36],
  //        seed_value[99:68], init_value[131:100], zero fill[135:132]
  input  wire logic [135:0] s_axis_tdata_i,
  // tuser: mode[3:0]
  input  wire logic [3:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // tdata: value[31:0], current_seed[63:32], initial_seed[95:64]
  output logic [95:0]       m_axis_tdata_o
);
  import msxp_pkg::*;

  `include "multi_stream_xorshift_prng_core_defines.svh"

  state_e state_q, state_d;

  // Request fields, held for the whole request.
  logic [3:0]  mode_q;
  logic [3:0]  class_q;
  logic [31:0] a_q, b_q, sv_q, iv_q;

  // Working registers.
  logic [31:0] cur_q, cur_d;
  logic [31:0] ini_q, ini_d;
  logic [31:0] adv_q, adv_d;
  logic [31:0] span_q, span_d;
  logic [31:0] chain_q, chain_d;
  logic [CLS_AW-1:0] idx_q, idx_d;

  logic [NUM_CLASSES-1:0] cur_vld_q, cur_vld_d;
  logic [NUM_CLASSES-1:0] ini_vld_q, ini_vld_d;

  logic        out_valid_q, out_valid_d;
  logic [95:0] out_data_q, out_data_d;

  logic              accept;
  logic              cls_ok;
  logic [CLS_AW-1:0] cls_addr;

  // Memory ports.
  logic              cur_we, ini_we;
  logic [CLS_AW-1:0] waddr;
  logic [31:0]       cur_wdata, ini_wdata;
  logic [31:0]       cur_rdata, ini_rdata;
  logic [CLS_AW-1:0] raddr;

  logic [FRAC_W-1:0] frac;
  logic [31:0]       scaled;
  logic [31:0]       value;
  logic [31:0]       res_cur, res_ini;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign raddr           = CLS_AW'(s_axis_tdata_i[3:0]);
  assign cls_addr        = CLS_AW'(class_q);
  assign cls_ok          = (32'(class_q) < NUM_CLASSES);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  msxp_ram #(.WIDTH(SEED_W), .DEPTH(NUM_CLASSES)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (waddr),
    .wdata_i (cur_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (cur_rdata)
  );

  msxp_ram #(.WIDTH(SEED_W), .DEPTH(NUM_CLASSES)) u_ini_ram (
    .clk_i   (clk_i),
    .we_i    (ini_we),
    .waddr_i (waddr),
    .wdata_i (ini_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (ini_rdata)
  );

  msxp_draw u_draw (
    .clk_i    (clk_i),
    .seed_i   (adv_q),
    .scale_i  ($signed(span_q)),
    .frac_o   (frac),
    .scaled_o (scaled)
  );

  // Result value and seeds for the finishing cycle.
  always_comb begin
    value   = '0;
    res_cur = cur_q;
    res_ini = ini_q;
    unique case (mode_q)
      MODE_FRAC:   begin value = 32'(frac);                    res_cur = adv_q; end
      MODE_BYTE:   begin value = 32'(frac[FRAC_W-1:BYTE_SHIFT]); res_cur = adv_q; end
      MODE_KEY:    begin value = scaled;                       res_cur = adv_q; end
      MODE_RANGE:  begin value = scaled + a_q;                 res_cur = adv_q; end
      MODE_PEEK:   value = 32'(frac);
      MODE_SET: begin
        res_cur = seed_nz(sv_q);
        res_ini = seed_nz(sv_q);
      end
      MODE_SETALL: begin
        res_cur = seed_nz(sv_q);
        res_ini = seed_nz(iv_q);
      end
      default:     value = '0;
    endcase
    if (!cls_ok) begin
      value   = '0;
      res_cur = '0;
      res_ini = '0;
    end
  end

  // Next state, memory writes and output load.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    ini_d       = ini_q;
    adv_d       = adv_q;
    span_d      = span_q;
    chain_d     = chain_q;
    idx_d       = idx_q;
    cur_vld_d   = cur_vld_q;
    ini_vld_d   = ini_vld_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    cur_we      = 1'b0;
    ini_we      = 1'b0;
    waddr       = cls_addr;
    cur_wdata   = res_cur;
    ini_wdata   = res_ini;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == MODE_RESEED) begin
            chain_d = seed_nz(s_axis_tdata_i[99:68]);
            idx_d   = '0;
            state_d = S_SWEEP;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        // Entries never written read as zero.
        cur_d  = cur_vld_q[cls_addr] ? cur_rdata : '0;
        ini_d  = ini_vld_q[cls_addr] ? ini_rdata : '0;
        adv_d  = xs_advance(cur_d);
        span_d = (mode_q == MODE_RANGE) ? (b_q - a_q + 32'd1) : a_q;
        state_d = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_FIN;
      S_SWEEP: begin
        cur_we    = 1'b1;
        ini_we    = 1'b1;
        waddr     = idx_q;
        cur_wdata = chain_q;
        ini_wdata = chain_q;
        cur_vld_d[idx_q] = 1'b1;
        ini_vld_d[idx_q] = 1'b1;
        // Capture the seeds given to the requested class.
        if (idx_q == cls_addr) begin
          cur_d = chain_q;
          ini_d = chain_q;
        end
        chain_d = xs_scramble(chain_q);
        idx_d   = idx_q + CLS_AW'(1);
        if (idx_q == CLS_AW'(NUM_CLASSES - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hold here until the output register is free.
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {res_ini, res_cur, value};
          if (cls_ok) begin
            unique case (mode_q)
              MODE_FRAC, MODE_BYTE, MODE_KEY, MODE_RANGE: begin
                cur_we = 1'b1;
                cur_vld_d[cls_addr] = 1'b1;
              end
              MODE_SET, MODE_SETALL: begin
                cur_we = 1'b1;
                ini_we = 1'b1;
                cur_vld_d[cls_addr] = 1'b1;
                ini_vld_d[cls_addr] = 1'b1;
              end
              default: ;
            endcase
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_vld_q   <= '0;
      ini_vld_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      cur_vld_q   <= cur_vld_d;
      ini_vld_q   <= ini_vld_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= s_axis_tuser_i;
      class_q <= s_axis_tdata_i[3:0];
      a_q     <= s_axis_tdata_i[35:4];
      b_q     <= s_axis_tdata_i[67:36];
      sv_q    <= s_axis_tdata_i[99:68];
      iv_q    <= s_axis_tdata_i[131:100];
    end
    cur_q      <= cur_d;
    ini_q      <= ini_d;
    adv_q      <= adv_d;
    span_q     <= span_d;
    chain_q    <= chain_d;
    out_data_q <= out_data_d;
  end

  `MSXP_ASSERT(a_accept_starts, accept |=> (state_q == S_READ || state_q == S_SWEEP),
               "accepted request did not start")
  `MSXP_NEVER(a_no_idle_write, (state_q == S_IDLE) && (cur_we || ini_we),
              "seed memory written while idle")
  `MSXP_ASSERT(a_result_from_fin, $rose(m_axis_tvalid_o) |-> $past(state_q == S_FIN),
               "result beat not from finish state")

endmodule

`default_nettype wire

>>> tb/xorshift_bank_checker.sv
`timescale 1ns / 1ps
// Response checker for the multi-stream xorshift generator bank.
// Keeps its own copy of both seed banks, predicts each response beat and compares.
// Depends on msxp_pkg for the mode codes and bank constants.

module xorshift_bank_checker
  import msxp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,
  input  wire logic         req_ready_i,
  // class_index[3:0], first_bound[35:4], second_bound[67:36],
  // seed_value[99:68], init_value[131:100], zero fill[135:132]
  input  wire logic [135:0] req_data_i,
  // mode[3:0]
  input  wire logic [3:0]   req_mode_i,
  input  wire logic         rsp_valid_i,
  input  wire logic         rsp_ready_i,
  // value[31:0], current_seed[63:32], initial_seed[95:64]
  input  wire logic [95:0]  rsp_data_i,
  output int                error_count_o,
  output int                pending_o,
  output int                checked_o
);

  typedef struct packed {
    logic [31:0] init_seed;
    logic [31:0] cur_seed;
    logic [31:0] value;
  } bank_rsp_t;

  logic [31:0] cur_seeds  [NUM_CLASSES];
  logic [31:0] init_seeds [NUM_CLASSES];
  bank_rsp_t   awaited_rsps [$];
  bank_rsp_t   oldest_rsp;

  function automatic logic [31:0] xorshift_next(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s >> 13);
    t = t ^ (t >> 11);
    return t ^ (t << 21);
  endfunction

  function automatic logic [31:0] chain_next(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s >> 13);
    t = t ^ (t << 25);
    return t ^ (t >> 11);
  endfunction

  function automatic logic [15:0] mixed_fraction(input logic [31:0] s);
    logic [31:0] prod;
    prod = s * MIX_MULT;
    return prod[FRAC_SHIFT +: FRAC_W];
  endfunction

  function automatic logic [31:0] or_default(input logic [31:0] s);
    return (s == 32'd0) ? SEED_DEFAULT : s;
  endfunction

  // floor(f * signed(m) / 65536), kept to 32 bits
  function automatic logic [31:0] scaled_fraction(input logic [15:0] f, input logic [31:0] m);
    logic signed [63:0] prod;
    prod = $signed({48'd0, f}) * $signed({{32{m[31]}}, m});
    prod = prod >>> 16;
    return prod[31:0];
  endfunction

  // Apply one request to the local banks and return the beat it must produce.
  function automatic bank_rsp_t bank_response(input logic [3:0] mode, input logic [3:0] cls,
                                              input logic [31:0] lo, input logic [31:0] hi,
                                              input logic [31:0] sv, input logic [31:0] iv);
    bank_rsp_t   r;
    logic [31:0] s;
    logic [15:0] f;
    logic        in_range;
    r = '0;
    in_range = int'(cls) < NUM_CLASSES;
    if (mode == MODE_RESEED) begin
      s = or_default(sv);
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cur_seeds[i]  = s;
        init_seeds[i] = s;
        s = chain_next(s);
      end
    end else if (in_range) begin
      s = cur_seeds[cls];
      case (mode)
        MODE_FRAC, MODE_BYTE, MODE_KEY, MODE_RANGE: begin
          s = xorshift_next(s);
          cur_seeds[cls] = s;
          f = mixed_fraction(s);
          case (mode)
            MODE_FRAC: r.value = {16'd0, f};
            MODE_BYTE: r.value = {24'd0, f[15:8]};
            MODE_KEY:  r.value = scaled_fraction(f, lo);
            default:   r.value = scaled_fraction(f, hi - lo + 32'd1) + lo;
          endcase
        end
        MODE_PEEK: r.value = {16'd0, mixed_fraction(xorshift_next(s))};
        MODE_SET: begin
          cur_seeds[cls]  = or_default(sv);
          init_seeds[cls] = or_default(sv);
        end
        MODE_SETALL: begin
          init_seeds[cls] = or_default(iv);
          cur_seeds[cls]  = or_default(sv);
        end
        default: ;
      endcase
    end
    if (in_range) begin
      r.cur_seed  = cur_seeds[cls];
      r.init_seed = init_seeds[cls];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      error_count_o++;
      if (error_count_o <= 10)
        $display("check: beat %0d field %s expected %h got %h", checked_o, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cur_seeds[i]  = '0;
        init_seeds[i] = '0;
      end
      awaited_rsps.delete();
      error_count_o = 0;
      checked_o     = 0;
      pending_o     = 0;
    end else begin
      // Response side first: a beat leaving now belongs to an older request.
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsps.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10)
            $display("check: unexpected response beat %h", rsp_data_i);
        end else begin
          oldest_rsp = awaited_rsps.pop_front();
          check_field("value", oldest_rsp.value, rsp_data_i[31:0]);
          check_field("current_seed", oldest_rsp.cur_seed, rsp_data_i[63:32]);
          check_field("initial_seed", oldest_rsp.init_seed, rsp_data_i[95:64]);
        end
        checked_o++;
      end
      if (req_valid_i && req_ready_i)
        awaited_rsps.push_back(bank_response(req_mode_i, req_data_i[3:0], req_data_i[35:4],
                                             req_data_i[67:36], req_data_i[99:68],
                                             req_data_i[131:100]));
      pending_o = awaited_rsps.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for multi_stream_xorshift_prng_core: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on msxp_pkg and xorshift_bank_checker.

module testbench;
  import msxp_pkg::*;

  // Mode codes the bank does not define; they must behave like a query.
  localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  localparam int ITEMS_PER_PHASE = 550;
  localparam int STALL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 30;

  // Hold every input at a known value from time zero.
  logic         clk      = 1'b0;
  logic         rst_n    = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [135:0] s_tdata  = '0;
  logic [3:0]   s_tuser  = '0;
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [95:0]  m_tdata;

  int send_idle_pct = 30;
  int recv_idle_pct = 47;
  int phase         = 0;
  logic hold_off    = 1'b0;
  int quiet_cycles  = 0;
  int requests_sent = 0;

  int error_count;
  int pending_rsps;
  int checked_rsps;

  always #10 clk = ~clk;

  multi_stream_xorshift_prng_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  xorshift_bank_checker checker_inst (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (s_tvalid),
    .req_ready_i   (s_tready),
    .req_data_i    (s_tdata),
    .req_mode_i    (s_tuser),
    .rsp_valid_i   (m_tvalid),
    .rsp_ready_i   (m_tready),
    .rsp_data_i    (m_tdata),
    .error_count_o (error_count),
    .pending_o     (pending_rsps),
    .checked_o     (checked_rsps)
  );

  // Receiver: drop ready at random, or hold it low for the whole stall window.
  always @(posedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long output stall in the last phase: the sender keeps offering, so the
  // core fills up and must drop its input ready.
  initial begin : rsp_stall
    int n;
    wait (phase == 2);
    repeat (40) @(posedge clk);
    hold_off <= 1'b1;
    for (n = 0; n < STALL_CYCLES; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                 quiet_cycles, pending_rsps);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one request beat and wait until the core takes it. Random idle
  // cycles go in front; tvalid stays high between back-to-back beats.
  task automatic send_request(input logic [3:0] mode, input logic [3:0] cls,
                              input logic [31:0] lo, input logic [31:0] hi,
                              input logic [31:0] sv, input logic [31:0] iv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'd0, iv, sv, hi, lo, cls};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Bounds: small signed values (-300 to 300) in 40% of picks so keys and ranges land near zero,
  // some extremes, the rest full 32-bit noise.
  function automatic logic [31:0] pick_bound();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 32'($urandom_range(0, 600)) - 32'd300;
    if (pick < 45) return 32'h8000_0000;
    if (pick < 50) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  // Seeds: now and then zero, to exercise the default substitution.
  function automatic logic [31:0] pick_seed();
    if ($urandom_range(0, 99) < 8) return 32'd0;
    return $urandom;
  endfunction

  task automatic random_request();
    logic [3:0] mode;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 18)      mode = MODE_FRAC;
    else if (pick < 30) mode = MODE_BYTE;
    else if (pick < 48) mode = MODE_KEY;
    else if (pick < 66) mode = MODE_RANGE;
    else if (pick < 73) mode = MODE_PEEK;
    else if (pick < 77) mode = MODE_QUERY;
    else if (pick < 85) mode = MODE_SET;
    else if (pick < 92) mode = MODE_SETALL;
    else if (pick < 96) mode = MODE_RESEED;
    else mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    send_request(mode, 4'($urandom_range(0, 15)), pick_bound(), pick_bound(),
                 pick_seed(), pick_seed());
  endtask

  initial begin : stimulus
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Untouched classes: zero seed draws zero (plus the low bound for a range) and stays zero.
    send_request(MODE_QUERY, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_FRAC,  4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_PEEK,  4'd3, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_RANGE, 4'd4, 32'd7, 32'd9, 32'd0, 32'd0);
    // Seed writes: zero takes the default, all-ones and one pass through.
    send_request(MODE_SET,    4'd0,  32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_SET,    4'd15, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_request(MODE_SETALL, 4'd1,  32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_SETALL, 4'd2,  32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
    // Fraction, byte and key draws on the written classes.
    send_request(MODE_FRAC, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_BYTE, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_KEY,  4'd0,  32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_KEY,  4'd0,  32'd1, 32'd0, 32'd0, 32'd0);
    send_request(MODE_KEY,  4'd1,  32'd65536, 32'd0, 32'd0, 32'd0);
    send_request(MODE_KEY,  4'd1,  32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_request(MODE_KEY,  4'd2,  32'h8000_0000, 32'd0, 32'd0, 32'd0);
    send_request(MODE_KEY,  4'd2,  32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    // Ranges: full span wraps to zero, single value, negative span, bounds across the sign; then a peek.
    send_request(MODE_RANGE, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_request(MODE_RANGE, 4'd15, 32'd5, 32'd5, 32'd0, 32'd0);
    send_request(MODE_RANGE, 4'd0,  32'd10, 32'd0, 32'd0, 32'd0);
    send_request(MODE_RANGE, 4'd1,  32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
    send_request(MODE_PEEK,  4'd15, 32'd0, 32'd0, 32'd0, 32'd0);
    // Unused codes act as a query.
    send_request(MODE_UNUSED_LO, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
    send_request(MODE_UNUSED_HI, 4'd2, 32'd0, 32'd0, 32'd0, 32'd0);
    // Reseed every class from the default and from all-ones, then draw.
    send_request(MODE_RESEED, 4'd9,  32'd0, 32'd0, 32'd0, 32'd0);
    send_request(MODE_RESEED, 4'd3,  32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_request(MODE_FRAC,   4'd7,  32'd0, 32'd0, 32'd0, 32'd0);

    // Random traffic in three idle patterns.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 30 : (p == 1) ? 47 : 0;
      recv_idle_pct <= (p == 0) ? 47 : (p == 1) ? 30 : 0;
      phase <= p;
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_request();
    end
    s_tvalid <= 1'b0;

    // Drain, then keep the clock running for a tail in which the core can show any stray beat.
    while (pending_rsps != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d requests over all modes, unused codes, zero seeds and reseeds",
             requests_sent);
    $display("summary: %0d response beats checked, idle mixes plus a %0d-cycle output stall",
             checked_rsps, STALL_CYCLES);
    if (error_count == 0 && pending_rsps == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/msxp_pkg.sv
hdl/msxp_ram.sv
hdl/msxp_draw.sv
hdl/multi_stream_xorshift_prng_core.sv
tb/xorshift_bank_checker.sv
tb/testbench.sv
